/* sv/trme_pkg.sv */
// ----------------------------------------------------------------------------
// trme_pkg: shared types and constants for the tiny register machine executor
// Opcodes, operand kinds, status codes, cost table and inter-module structs.
// ----------------------------------------------------------------------------
package trme_pkg;

    localparam int DATA_W    = 32;
    localparam int NUM_REGS  = 8;
    localparam int MEM_WORDS = 64;
    localparam int RIDX_W    = $clog2(NUM_REGS);
    localparam int MADDR_W   = $clog2(MEM_WORDS);
    localparam int PRELOAD_N = 3;
    localparam int CFG_IDX_W = 2;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 72;

    // opcodes
    localparam logic [3:0] OP_MOV  = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_DIV  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_XOR  = 4'd6;
    localparam logic [3:0] OP_OR   = 4'd7;
    localparam logic [3:0] OP_EXIT = 4'd8;

    // operand kinds
    localparam logic [1:0] KIND_REG   = 2'd0;
    localparam logic [1:0] KIND_MEM   = 2'd1;
    localparam logic [1:0] KIND_CONST = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // result status
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_WARN     = 4'd1;
    localparam logic [3:0] ST_EXIT0    = 4'd2;
    localparam logic [3:0] ST_EXIT1    = 4'd3;
    localparam logic [3:0] ST_MISALIGN = 4'd4;
    localparam logic [3:0] ST_INVALID  = 4'd5;
    localparam logic [3:0] ST_UNINIT   = 4'd6;
    localparam logic [3:0] ST_DIVZERO  = 4'd7;
    localparam logic [3:0] ST_UNKNOWN  = 4'd8;
    localparam logic [3:0] ST_HALTED   = 4'd9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRELOAD0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRELOAD1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRELOAD2 = 2'd2;

    localparam logic [DATA_W-1:0] PRELOAD0_RST = 32'd57;
    localparam logic [DATA_W-1:0] PRELOAD1_RST = 32'd23;
    localparam logic [DATA_W-1:0] PRELOAD2_RST = 32'd101;

    // cycle costs
    localparam logic [DATA_W-1:0] COST_SIMPLE = 32'd10;
    localparam logic [DATA_W-1:0] COST_MUL    = 32'd30;
    localparam logic [DATA_W-1:0] COST_DIV    = 32'd50;
    localparam logic [DATA_W-1:0] COST_MEM    = 32'd200;
    localparam logic [DATA_W-1:0] COST_EXIT   = 32'd20;

    typedef struct packed {
        logic               rf_we;
        logic [RIDX_W-1:0]  rf_waddr;
        logic [DATA_W-1:0]  rf_wdata;
        logic               mem_we;
        logic [MADDR_W-1:0] mem_waddr;
        logic [DATA_W-1:0]  mem_wdata;
    } t_st_wr;

    typedef struct packed {
        logic       start;
        logic [3:0] op;
    } t_alu_req;

endpackage

/* sv/trme_alu.sv */
// ----------------------------------------------------------------------------
// trme_alu: shared arithmetic unit
// Add/sub/mul/logic results are registered; radix-2 restoring divide over 32 steps
// plus a final sign fix. o_done pulses with the registered result.
// ----------------------------------------------------------------------------
module trme_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  trme_pkg::t_alu_req            i_req,
    input  logic [trme_pkg::DATA_W-1:0]   i_a,
    input  logic [trme_pkg::DATA_W-1:0]   i_b,
    output logic                          o_done,
    output logic [trme_pkg::DATA_W-1:0]   o_result
);

    localparam int CNT_W = $clog2(trme_pkg::DATA_W);

    logic                        r_busy;
    logic                        r_fix;
    logic                        r_done;
    logic                        r_neg;
    logic [CNT_W-1:0]            r_cnt;
    logic [trme_pkg::DATA_W-1:0] r_rem;
    logic [trme_pkg::DATA_W-1:0] r_quo;
    logic [trme_pkg::DATA_W-1:0] r_dvs;
    logic [trme_pkg::DATA_W-1:0] r_res;

    logic [trme_pkg::DATA_W:0]   shifted;
    logic [trme_pkg::DATA_W:0]   diff;
    logic [trme_pkg::DATA_W-1:0] mag_a;
    logic [trme_pkg::DATA_W-1:0] mag_b;
    logic [trme_pkg::DATA_W-1:0] simple_res;

    assign mag_a   = i_a[trme_pkg::DATA_W-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b   = i_b[trme_pkg::DATA_W-1] ? (~i_b + 1'b1) : i_b;
    assign shifted = {r_rem, r_quo[trme_pkg::DATA_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_comb begin
        unique case (i_req.op)
            trme_pkg::OP_ADD: simple_res = i_a + i_b;
            trme_pkg::OP_SUB: simple_res = i_a - i_b;
            trme_pkg::OP_MUL: simple_res = i_a * i_b;
            trme_pkg::OP_AND: simple_res = i_a & i_b;
            trme_pkg::OP_XOR: simple_res = i_a ^ i_b;
            default:          simple_res = i_a | i_b;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.op == trme_pkg::OP_DIV) begin
                    r_busy <= 1'b1;
                end else begin
                    r_done <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(trme_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_res <= simple_res;
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= mag_a;
            r_dvs <= mag_b;
            r_neg <= i_a[trme_pkg::DATA_W-1] ^ i_b[trme_pkg::DATA_W-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (!diff[trme_pkg::DATA_W]) begin
                r_rem <= diff[trme_pkg::DATA_W-1:0];
                r_quo <= {r_quo[trme_pkg::DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[trme_pkg::DATA_W-1:0];
                r_quo <= {r_quo[trme_pkg::DATA_W-2:0], 1'b0};
            end
        end else if (r_fix) begin
            r_res <= r_neg ? (~r_quo + 1'b1) : r_quo;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

/* sv/trme_store.sv */
// ----------------------------------------------------------------------------
// trme_store: register file and data memory with initialized bits
// Registered reads. Words below PRELOAD_N live in flops, reset to preload values and loaded by config.
// A memory word at or above PRELOAD_N that was never written reads as zero.
// ----------------------------------------------------------------------------
module trme_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  trme_pkg::t_st_wr                  i_wr,
    input  logic                              i_cfg_we,
    input  logic [trme_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [trme_pkg::DATA_W-1:0]       i_cfg_data,
    input  logic [trme_pkg::RIDX_W-1:0]       i_rf_raddr_a,
    input  logic [trme_pkg::RIDX_W-1:0]       i_rf_raddr_b,
    input  logic [trme_pkg::MADDR_W-1:0]      i_mem_raddr,
    output logic [trme_pkg::DATA_W-1:0]       o_rf_qa,
    output logic [trme_pkg::DATA_W-1:0]       o_rf_qb,
    output logic [trme_pkg::NUM_REGS-1:0]     o_rf_vld,
    output logic [trme_pkg::DATA_W-1:0]       o_mem_q,
    output logic                              o_mem_vld
);

    logic [trme_pkg::DATA_W-1:0] rf  [trme_pkg::NUM_REGS];
    logic [trme_pkg::DATA_W-1:0] mem [trme_pkg::MEM_WORDS];

    logic [trme_pkg::NUM_REGS-1:0]  r_rfv;
    logic [trme_pkg::MEM_WORDS-1:0] r_mvld;
    logic [trme_pkg::DATA_W-1:0]    r_low0;
    logic [trme_pkg::DATA_W-1:0]    r_low1;
    logic [trme_pkg::DATA_W-1:0]    r_low2;

    logic [trme_pkg::DATA_W-1:0]    r_rf_qa;
    logic [trme_pkg::DATA_W-1:0]    r_rf_qb;
    logic [trme_pkg::DATA_W-1:0]    r_arr_q;
    logic [trme_pkg::DATA_W-1:0]    r_low_q;
    logic                           r_low_hit;
    logic                           r_mem_vld_q;

    logic [trme_pkg::DATA_W-1:0]    low_rd;
    logic                           wr_low;
    logic                           rd_low;

    assign wr_low = 32'(i_wr.mem_waddr) < 32'(trme_pkg::PRELOAD_N);
    assign rd_low = 32'(i_mem_raddr) < 32'(trme_pkg::PRELOAD_N);

    always_comb begin
        unique case (i_mem_raddr)
            trme_pkg::MADDR_W'(0): low_rd = r_low0;
            trme_pkg::MADDR_W'(1): low_rd = r_low1;
            trme_pkg::MADDR_W'(2): low_rd = r_low2;
            default:               low_rd = '0;
        endcase
    end

    // control and preloaded words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rfv  <= '0;
            r_mvld <= {{(trme_pkg::MEM_WORDS - trme_pkg::PRELOAD_N){1'b0}},
                       {trme_pkg::PRELOAD_N{1'b1}}};
            r_low0 <= trme_pkg::PRELOAD0_RST;
            r_low1 <= trme_pkg::PRELOAD1_RST;
            r_low2 <= trme_pkg::PRELOAD2_RST;
        end else begin
            if (i_wr.rf_we) begin
                r_rfv[i_wr.rf_waddr] <= 1'b1;
            end
            if (i_wr.mem_we) begin
                r_mvld[i_wr.mem_waddr] <= 1'b1;
                if (wr_low) begin
                    unique case (i_wr.mem_waddr)
                        trme_pkg::MADDR_W'(0): r_low0 <= i_wr.mem_wdata;
                        trme_pkg::MADDR_W'(1): r_low1 <= i_wr.mem_wdata;
                        default:               r_low2 <= i_wr.mem_wdata;
                    endcase
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    trme_pkg::CFG_PRELOAD0: begin
                        r_low0    <= i_cfg_data;
                        r_mvld[0] <= 1'b1;
                    end
                    trme_pkg::CFG_PRELOAD1: begin
                        r_low1    <= i_cfg_data;
                        r_mvld[1] <= 1'b1;
                    end
                    trme_pkg::CFG_PRELOAD2: begin
                        r_low2    <= i_cfg_data;
                        r_mvld[2] <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.rf_we) begin
            rf[i_wr.rf_waddr] <= i_wr.rf_wdata;
        end
        r_rf_qa <= rf[i_rf_raddr_a];
        r_rf_qb <= rf[i_rf_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.mem_we && !wr_low) begin
            mem[i_wr.mem_waddr] <= i_wr.mem_wdata;
        end
        r_arr_q     <= mem[i_mem_raddr];
        r_low_q     <= low_rd;
        r_low_hit   <= rd_low;
        r_mem_vld_q <= r_mvld[i_mem_raddr];
    end

    assign o_rf_qa   = r_rf_qa;
    assign o_rf_qb   = r_rf_qb;
    assign o_rf_vld  = r_rfv;
    assign o_mem_vld = r_mem_vld_q;
    assign o_mem_q   = !r_mem_vld_q ? '0 : (r_low_hit ? r_low_q : r_arr_q);

endmodule

/* sv/tiny_register_machine_executor_unit.sv */
// ----------------------------------------------------------------------------
// tiny_register_machine_executor_unit: executes one pre-decoded instruction
// per item on 8 registers and 64 memory words, with checks and cycle costs.
// ----------------------------------------------------------------------------
// States from accept to result valid: DEC, DONE for EXIT, decode errors and halted
// items; DEC, EXE, DONE for MOV and divide by zero; DEC, EXE, ALU, DONE for ADD/SUB/
// MUL/AND/XOR/OR and DIV (32 divide steps in the shared ALU plus sign fix). One item
// at a time: the next item is taken in the cycle after the output register is loaded.
// Reset (synchronous, active low) clears register valid bits, cycle count and
// halt flag, and loads memory words 0-2 with 57, 23, 101.
module tiny_register_machine_executor_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: opcode[3:0], dest_number[11:4], src_number[42:12], zero pad
    input  logic [trme_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser: dest_kind[1:0], src_kind[3:2]
    input  logic [trme_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: status[3:0], written_value[35:4], cycle_total[67:36],
    //        halted[68], zero pad
    output logic [trme_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [trme_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [trme_pkg::DATA_W-1:0]         i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_EXE  = 3'd2;
    localparam logic [2:0] S_ALU  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [2:0] CLS_MOV_RR = 3'd0;
    localparam logic [2:0] CLS_MOV_RM = 3'd1;
    localparam logic [2:0] CLS_MOV_MR = 3'd2;
    localparam logic [2:0] CLS_MOV_RC = 3'd3;
    localparam logic [2:0] CLS_ALU    = 3'd4;

    localparam int DW = trme_pkg::DATA_W;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_op;
    logic [1:0]  r_dk;
    logic [7:0]  r_dn;
    logic [1:0]  r_sk;
    logic [30:0] r_sn;
    logic [2:0]  r_cls, n_cls;
    logic [3:0]  r_status, n_status;
    logic [DW-1:0] r_value, n_value;
    logic [DW-1:0] r_cyc, n_cyc;
    logic        r_stop, n_stop;

    logic          r_ov;
    logic [3:0]    r_o_status;
    logic [DW-1:0] r_o_value;
    logic [DW-1:0] r_o_cyc;
    logic          r_o_halt;

    logic in_acc;
    logic out_load;

    logic [trme_pkg::RIDX_W-1:0]   rd_idx;
    logic [trme_pkg::RIDX_W-1:0]   rs_idx;
    logic [trme_pkg::MADDR_W-1:0]  dst_word;
    logic [trme_pkg::MADDR_W-1:0]  src_word;

    logic          d_fail;
    logic          d_exit;
    logic [3:0]    d_status;
    logic [2:0]    d_cls;

    trme_pkg::t_st_wr   wr;
    trme_pkg::t_alu_req alu_req;

    logic [DW-1:0] rf_qa;
    logic [DW-1:0] rf_qb;
    logic [trme_pkg::NUM_REGS-1:0] rf_vld;
    logic [DW-1:0] mem_q;
    logic          mem_vld;
    logic          alu_done;
    logic [DW-1:0] alu_res;
    logic [DW-1:0] alu_cost;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign rd_idx   = r_dn[trme_pkg::RIDX_W-1:0];
    assign rs_idx   = r_sn[trme_pkg::RIDX_W-1:0];
    assign dst_word = trme_pkg::MADDR_W'(32'(r_dn) >> 2);
    assign src_word = trme_pkg::MADDR_W'(32'(r_sn) >> 2);

    // operand decode: destination, then source, then opcode
    always_comb begin
        d_fail   = 1'b1;
        d_exit   = 1'b0;
        d_status = trme_pkg::ST_INVALID;
        d_cls    = CLS_MOV_RC;
        priority if (r_dk == trme_pkg::KIND_REG &&
                     32'(r_dn) >= 32'(trme_pkg::NUM_REGS)) begin
            d_status = trme_pkg::ST_INVALID;
        end else if (r_dk == trme_pkg::KIND_MEM && r_dn[1:0] != 2'd0) begin
            d_status = trme_pkg::ST_MISALIGN;
        end else if (r_dk == trme_pkg::KIND_MEM &&
                     (32'(r_dn) >> 2) >= 32'(trme_pkg::MEM_WORDS)) begin
            d_status = trme_pkg::ST_INVALID;
        end else if (r_dk == trme_pkg::KIND_CONST && r_op == trme_pkg::OP_EXIT &&
                     r_dn <= 8'd1) begin
            d_fail = 1'b0;
            d_exit = 1'b1;
        end else if (r_dk == trme_pkg::KIND_CONST || r_dk == trme_pkg::KIND_NONE) begin
            d_status = trme_pkg::ST_INVALID;
        end else if (r_sk == trme_pkg::KIND_REG &&
                     32'(r_sn) >= 32'(trme_pkg::NUM_REGS)) begin
            d_status = trme_pkg::ST_INVALID;
        end else if (r_sk == trme_pkg::KIND_MEM && r_sn[1:0] != 2'd0) begin
            d_status = trme_pkg::ST_MISALIGN;
        end else if (r_sk == trme_pkg::KIND_MEM &&
                     (32'(r_sn) >> 2) >= 32'(trme_pkg::MEM_WORDS)) begin
            d_status = trme_pkg::ST_INVALID;
        end else if (r_sk == trme_pkg::KIND_NONE) begin
            d_status = trme_pkg::ST_INVALID;
        end else if (r_op == trme_pkg::OP_MOV) begin
            priority if (r_dk == trme_pkg::KIND_REG && r_sk == trme_pkg::KIND_REG) begin
                if (!rf_vld[rs_idx]) begin
                    d_status = trme_pkg::ST_UNINIT;
                end else begin
                    d_fail = 1'b0;
                    d_cls  = CLS_MOV_RR;
                end
            end else if (r_dk == trme_pkg::KIND_REG && r_sk == trme_pkg::KIND_MEM) begin
                d_fail = 1'b0;
                d_cls  = CLS_MOV_RM;
            end else if (r_dk == trme_pkg::KIND_MEM && r_sk == trme_pkg::KIND_REG) begin
                if (!rf_vld[rs_idx]) begin
                    d_status = trme_pkg::ST_UNINIT;
                end else begin
                    d_fail = 1'b0;
                    d_cls  = CLS_MOV_MR;
                end
            end else if (r_dk == trme_pkg::KIND_REG && r_sk == trme_pkg::KIND_CONST) begin
                d_fail = 1'b0;
                d_cls  = CLS_MOV_RC;
            end else begin
                d_status = trme_pkg::ST_INVALID;
            end
        end else if (r_op >= trme_pkg::OP_ADD && r_op <= trme_pkg::OP_OR) begin
            priority if (r_dk != trme_pkg::KIND_REG || r_sk != trme_pkg::KIND_REG) begin
                d_status = trme_pkg::ST_INVALID;
            end else if (!rf_vld[rs_idx] || !rf_vld[rd_idx]) begin
                d_status = trme_pkg::ST_UNINIT;
            end else begin
                d_fail = 1'b0;
                d_cls  = CLS_ALU;
            end
        end else begin
            d_status = trme_pkg::ST_UNKNOWN;
        end
    end

    always_comb begin
        unique case (r_op)
            trme_pkg::OP_MUL: alu_cost = trme_pkg::COST_MUL;
            trme_pkg::OP_DIV: alu_cost = trme_pkg::COST_DIV;
            default:          alu_cost = trme_pkg::COST_SIMPLE;
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cls    = r_cls;
        n_status = r_status;
        n_value  = r_value;
        n_cyc    = r_cyc;
        n_stop   = r_stop;
        out_load = 1'b0;
        wr       = '0;
        alu_req  = '0;
        alu_req.op = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_value = '0;
                priority if (r_stop) begin
                    n_status = trme_pkg::ST_HALTED;
                    n_state  = S_DONE;
                end else if (d_exit) begin
                    n_status = r_dn[0] ? trme_pkg::ST_EXIT1 : trme_pkg::ST_EXIT0;
                    n_cyc    = r_cyc + trme_pkg::COST_EXIT;
                    n_stop   = 1'b1;
                    n_state  = S_DONE;
                end else if (d_fail) begin
                    n_status = d_status;
                    n_stop   = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_cls   = d_cls;
                    n_state = S_EXE;
                end
            end
            S_EXE: begin
                n_status = trme_pkg::ST_OK;
                n_state  = S_DONE;
                unique case (r_cls)
                    CLS_MOV_RR: begin
                        wr.rf_we    = 1'b1;
                        wr.rf_waddr = rd_idx;
                        wr.rf_wdata = rf_qb;
                        n_value     = rf_qb;
                        n_cyc       = r_cyc + trme_pkg::COST_SIMPLE;
                    end
                    CLS_MOV_RM: begin
                        wr.rf_we    = 1'b1;
                        wr.rf_waddr = rd_idx;
                        wr.rf_wdata = mem_q;
                        n_value     = mem_q;
                        n_status    = mem_vld ? trme_pkg::ST_OK : trme_pkg::ST_WARN;
                        n_cyc       = r_cyc + trme_pkg::COST_MEM;
                    end
                    CLS_MOV_MR: begin
                        wr.mem_we    = 1'b1;
                        wr.mem_waddr = dst_word;
                        wr.mem_wdata = rf_qb;
                        n_value      = rf_qb;
                        n_cyc        = r_cyc + trme_pkg::COST_MEM;
                    end
                    CLS_MOV_RC: begin
                        wr.rf_we    = 1'b1;
                        wr.rf_waddr = rd_idx;
                        wr.rf_wdata = {1'b0, r_sn};
                        n_value     = {1'b0, r_sn};
                        n_cyc       = r_cyc + trme_pkg::COST_SIMPLE;
                    end
                    default: begin
                        if (r_op == trme_pkg::OP_DIV && rf_qb == '0) begin
                            n_status = trme_pkg::ST_DIVZERO;
                            n_value  = '0;
                            n_stop   = 1'b1;
                        end else begin
                            alu_req.start = 1'b1;
                            n_state       = S_ALU;
                        end
                    end
                endcase
            end
            S_ALU: begin
                if (alu_done) begin
                    wr.rf_we    = 1'b1;
                    wr.rf_waddr = rd_idx;
                    wr.rf_wdata = alu_res;
                    n_value     = alu_res;
                    n_cyc       = r_cyc + alu_cost;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cyc   <= '0;
            r_stop  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cyc   <= n_cyc;
            r_stop  <= n_stop;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op <= i_s_axis_tdata[3:0];
            r_dn <= i_s_axis_tdata[11:4];
            r_sn <= i_s_axis_tdata[42:12];
            r_dk <= i_s_axis_tuser[1:0];
            r_sk <= i_s_axis_tuser[3:2];
        end
        r_cls    <= n_cls;
        r_status <= n_status;
        r_value  <= n_value;
        if (out_load) begin
            r_o_status <= r_status;
            r_o_value  <= r_value;
            r_o_cyc    <= r_cyc;
            r_o_halt   <= r_stop;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {3'b000, r_o_halt, r_o_cyc, r_o_value, r_o_status};

    trme_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (wr),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_rf_raddr_a (rd_idx),
        .i_rf_raddr_b (rs_idx),
        .i_mem_raddr  (src_word),
        .o_rf_qa      (rf_qa),
        .o_rf_qb      (rf_qb),
        .o_rf_vld     (rf_vld),
        .o_mem_q      (mem_q),
        .o_mem_vld    (mem_vld)
    );

    trme_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (rf_qa),
        .i_b      (rf_qb),
        .o_done   (alu_done),
        .o_result (alu_res)
    );

endmodule

/* sv/trme_chk.sv */
// ----------------------------------------------------------------------------
// trme_chk: port-level checks for the executor
// Halt stickiness, status/halt consistency, one-item-at-a-time intake, output hold.
// ----------------------------------------------------------------------------
module trme_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                i_s_tready,
    input logic                                i_m_tvalid,
    input logic                                i_m_tready,
    input logic [trme_pkg::OUT_TDATA_W-1:0]    i_m_tdata
);

    logic       r_seen_halt;
    logic [3:0] status;
    logic       halted;

    assign status = i_m_tdata[3:0];
    assign halted = i_m_tdata[68];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (i_m_tvalid && i_m_tready && halted) begin
            r_seen_halt <= 1'b1;
        end
    end

    // once stopped, every later item reports halted
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tready && r_seen_halt) |-> (status == trme_pkg::ST_HALTED))
        else $error("item after halt does not report halted status");

    a_intake_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("new item taken while previous one is in flight");

    a_stop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && status >= trme_pkg::ST_EXIT0) |-> halted)
        else $error("stopping status without halted flag");

    a_ok_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && (status == trme_pkg::ST_OK || status == trme_pkg::ST_WARN))
        |-> !halted)
        else $error("ok status with halted flag");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled result changed");

endmodule

bind tiny_register_machine_executor_unit trme_chk u_trme_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);
